FILE: rtl/cmap_pkg.sv
package cmap_pkg;

   localparam int DEF_MAX_WINDOW  = 63;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int WIN_W     = 6;
   localparam int GAIN_W    = 16;
   localparam int GAIN_FRAC = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VALUE = 2'd2;

   localparam logic [WIN_W-1:0]  WINDOW_RESET = 6'd5;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd4096;

   typedef struct packed {
      logic load;
      logic sum_run;
      logic mul;
      logic div_load;
      logic div_run;
      logic out_load;
      logic step_issue;
      logic step_acc;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic sum_done;
      logic emit_ok;
      logic div_done;
      logic out_free;
      logic more;
   } dp_status_type;

endpackage

FILE: rtl/cmap_csr.sv
module cmap_csr import cmap_pkg::*; #(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [((SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W)-1:0] csr_data,
   output logic [WIN_W-1:0]              win_n,
   output logic [WIN_W-1:0]              win_half,
   output logic [GAIN_W-1:0]             gain,
   output logic signed [SAMPLE_BITS-1:0] init_value
);

   // largest odd window that the history can hold
   localparam int CAP = (MAX_WINDOW - 1) | 1;

   logic [WIN_W-1:0]              window_length_ff;
   logic [GAIN_W-1:0]             gain_ff;
   logic signed [SAMPLE_BITS-1:0] init_ff;
   logic [WIN_W-1:0]              odd_n;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
         gain_ff          <= GAIN_RESET;
         init_ff          <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_data[WIN_W-1:0];
            CSR_GAIN:          gain_ff          <= csr_data[GAIN_W-1:0];
            CSR_INITIAL_VALUE: init_ff          <= csr_data[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // zero and even lengths both land on the next odd value
   assign odd_n = window_length_ff | WIN_W'(1);

   always_comb begin
      if (int'(odd_n) > CAP) begin
         win_n = WIN_W'(CAP);
      end else begin
         win_n = odd_n;
      end
   end

   assign win_half   = win_n >> 1;
   assign gain       = gain_ff;
   assign init_value = init_ff;

endmodule

FILE: rtl/cmap_ctrl.sv
module cmap_ctrl import cmap_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SUM   = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_DLOAD = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_OUT   = 4'd6;
   localparam logic [3:0] S_NEXT  = 4'd7;
   localparam logic [3:0] S_STEP  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum_run = 1'b1;
            if (status.sum_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // windows whose centre lies before the start of the sequence give no output yet
            state_in = status.emit_ok ? S_MUL : S_NEXT;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end else begin
               cmd.div_run = 1'b1;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_NEXT;
            end
         end
         S_NEXT: begin
            if (status.more) begin
               cmd.step_issue = 1'b1;
               state_in       = S_STEP;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_STEP: begin
            cmd.step_acc = 1'b1;
            state_in     = S_CHECK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/cmap_dp.sv
module cmap_dp import cmap_pkg::*; #(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   input  logic [WIN_W-1:0]              win_n,
   input  logic [WIN_W-1:0]              win_half,
   input  logic [GAIN_W-1:0]             gain,
   input  logic signed [SAMPLE_BITS-1:0] init_value,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [SAMPLE_BITS-1:0] rsp_smoothed,
   output logic                          rsp_last
);

   localparam int DEPTH  = MAX_WINDOW + 1;
   localparam int AW     = $clog2(DEPTH);
   localparam int SW     = $clog2(DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
   localparam int PROD_W = SUM_W + GAIN_W + 1;
   localparam int DIV_W  = PROD_W - GAIN_FRAC;
   localparam int CW     = $clog2(DIV_W + 1);

   localparam logic [DIV_W-1:0] POS_LIM = DIV_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] NEG_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // history ring, newest entry at wp_ff
   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

   logic [AW-1:0]                 wp_ff;
   logic [AW-1:0]                 wp_next;
   logic [SW-1:0]                 seen_ff;
   logic                          end_ff;
   logic [WIN_W-1:0]              d_ff;
   logic [WIN_W-1:0]              p_ff;
   logic signed [SAMPLE_BITS-1:0] last_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          rd_sel_ff;
   logic                          rd_vld_ff;
   logic signed [SUM_W-1:0]       acc_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic                          neg_ff;
   logic [DIV_W-1:0]              quo_ff;
   logic [WIN_W-1:0]              rem_ff;
   logic [CW-1:0]                 cnt_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_smoothed_ff;
   logic                          rsp_last_ff;

   logic [WIN_W-1:0]              rd_d;
   int                            rd_pos;
   logic [AW-1:0]                 rd_addr;
   logic                          rd_hit;
   logic                          issue;
   logic signed [SAMPLE_BITS-1:0] term;
   logic signed [SUM_W-1:0]       term_ext;
   logic signed [SUM_W-1:0]       last_ext;
   logic [PROD_W-1:0]             mag;
   logic [WIN_W:0]                r2;
   logic [WIN_W:0]                r2_diff;
   logic                          q_bit;
   logic [WIN_W-1:0]              rem_next;
   logic [DIV_W-1:0]              quo_neg;
   logic [SAMPLE_BITS-1:0]        sat;

   assign wp_next = (int'(wp_ff) == DEPTH - 1) ? '0 : wp_ff + AW'(1);

   // distance back from the newest sample: window walk or the term leaving on a flush step
   always_comb begin
      if (cmd.sum_run) begin
         rd_d = d_ff;
      end else begin
         rd_d = win_n - p_ff - WIN_W'(1);
      end
      rd_pos = int'(wp_ff) + DEPTH - int'(rd_d);
      if (rd_pos >= DEPTH) begin
         rd_pos = rd_pos - DEPTH;
      end
      rd_addr = AW'(rd_pos);
   end

   assign rd_hit = int'(rd_d) < int'(seen_ff);
   assign issue  = cmd.sum_run && (d_ff < win_n);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem[wp_next] <= req_sample;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // positions before the start of the sequence read as the initial value
   assign term     = rd_sel_ff ? rd_data_ff : init_value;
   assign term_ext = {{(SUM_W - SAMPLE_BITS){term[SAMPLE_BITS-1]}}, term};
   assign last_ext = {{(SUM_W - SAMPLE_BITS){last_ff[SAMPLE_BITS-1]}}, last_ff};

   assign mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);

   // restoring division, one quotient bit per cycle
   assign r2       = {rem_ff, quo_ff[DIV_W-1]};
   assign r2_diff  = r2 - {1'b0, win_n};
   assign q_bit    = r2 >= {1'b0, win_n};
   assign rem_next = q_bit ? r2_diff[WIN_W-1:0] : r2[WIN_W-1:0];

   assign quo_neg = -quo_ff;

   always_comb begin
      if (!neg_ff) begin
         sat = (quo_ff > POS_LIM) ? POS_MAX : quo_ff[SAMPLE_BITS-1:0];
      end else begin
         sat = (quo_ff > NEG_LIM) ? NEG_MIN : quo_neg[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         seen_ff      <= '0;
         end_ff       <= 1'b0;
         d_ff         <= '0;
         p_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (cmd.load) begin
            wp_ff  <= wp_next;
            end_ff <= req_last;
            d_ff   <= '0;
            p_ff   <= '0;
            if (int'(seen_ff) < DEPTH) begin
               seen_ff <= seen_ff + SW'(1);
            end
         end
         if (issue) begin
            d_ff <= d_ff + WIN_W'(1);
         end
         if (cmd.step_issue) begin
            p_ff <= p_ff + WIN_W'(1);
         end
         if (cmd.finish && end_ff) begin
            seen_ff <= '0;
         end
         if (cmd.div_load) begin
            cnt_ff <= CW'(DIV_W);
         end else if (cmd.div_run) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= rd_hit;
      if (cmd.load) begin
         last_ff <= req_sample;
         acc_ff  <= '0;
      end else if (rd_vld_ff) begin
         acc_ff <= acc_ff + term_ext;
      end else if (cmd.step_acc) begin
         // window slides past the end: last sample in, oldest term out
         acc_ff <= acc_ff + last_ext - term_ext;
      end
      if (cmd.mul) begin
         prod_ff <= $signed({1'b0, gain}) * acc_ff;
      end
      if (cmd.div_load) begin
         neg_ff <= prod_ff[PROD_W-1];
         quo_ff <= mag[PROD_W-1:GAIN_FRAC];
         rem_ff <= '0;
      end else if (cmd.div_run) begin
         rem_ff <= rem_next;
         quo_ff <= {quo_ff[DIV_W-2:0], q_bit};
      end
      if (cmd.out_load) begin
         rsp_smoothed_ff <= sat;
         rsp_last_ff     <= end_ff && (p_ff == win_half);
      end
   end

   assign status.sum_done = (d_ff == win_n) && !rd_vld_ff;
   assign status.emit_ok  = (int'(p_ff) + int'(seen_ff)) >= (int'(win_half) + 1);
   assign status.div_done = cnt_ff == '0;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign status.more     = end_ff && (p_ff < win_half);

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_smoothed = rsp_smoothed_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: rtl/centered_moving_average_padded_core.sv
// one request at a time; the window sum walks the history ram, one entry a cycle
// a request with no result only loads the sample and sums the window; a request with a result
// also multiplies by the gain and runs the divider for D = DIV_W quotient steps (27 by default)
// each extra result flushed by a last request takes a flush step, the multiply and the divide
// synchronous reset returns config to defaults and clears control; history ram is not cleared
module centered_moving_average_padded_core import cmap_pkg::*; #(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // sample
   input  logic                                   req_tlast,  // end_of_sequence
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // smoothed
   output logic                                   rsp_tlast,  // last_output
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [((SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W)-1:0] csr_data
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   dp_cmd_type                    dp_cmd;
   dp_status_type                 dp_status;
   logic [WIN_W-1:0]              win_n;
   logic [WIN_W-1:0]              win_half;
   logic [GAIN_W-1:0]             gain;
   logic signed [SAMPLE_BITS-1:0] init_value;
   logic signed [SAMPLE_BITS-1:0] rsp_smoothed;

   cmap_csr #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .win_n      (win_n),
      .win_half   (win_half),
      .gain       (gain),
      .init_value (init_value)
   );

   cmap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   cmap_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .req_sample   (req_tdata[SAMPLE_BITS-1:0]),
      .req_last     (req_tlast),
      .win_n        (win_n),
      .win_half     (win_half),
      .gain         (gain),
      .init_value   (init_value),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_smoothed (rsp_smoothed),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = TDATA_W'($unsigned(rsp_smoothed));

   // one datapath command at a time
   assert property (@(posedge clock) disable iff (reset) $onehot0(dp_cmd))
      else $error("datapath commands overlap");

   // a result is loaded only when the output register can take it
   assert property (@(posedge clock) disable iff (reset) dp_cmd.out_load |-> dp_status.out_free)
      else $error("result loaded over a pending result");

   // after a request is taken the block is busy with it
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while the previous one is in work");

endmodule
